FILE: hdl/pwrseq_pkg.sv
// Shared codes and reset constants for the power sequencer with keep-alive watchdog.
package pwrseq_pkg;

	// Control state codes
	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_OFF  = 2'd1;
	localparam logic [1:0] MODE_ON   = 2'd2;
	localparam logic [1:0] MODE_IDLE = 2'd3;

	// Item kinds carried on the input tuser
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_KEEPALIVE = 2'd1;
	localparam logic [1:0] ACT_SHUTDOWN  = 2'd2;
	localparam logic [1:0] ACT_UNUSED    = 2'd3;

	// Wake cause codes
	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_BUTTON   = 2'd1;
	localparam logic [1:0] CAUSE_IGNITION = 2'd2;
	localparam logic [1:0] CAUSE_CAN      = 2'd3;

	// Configuration register indexes
	localparam logic REG_KEEPALIVE  = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	// Register reset values
	localparam logic [15:0] KEEPALIVE_RESET  = 16'd500;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

	localparam int SD_W = 15;

	typedef struct packed {
		logic [1:0] control_state;
		logic       power_pin;
		logic [1:0] wake_cause;
		logic       can_seen;
		logic       sd_prepare;
	} result_t;

endpackage

FILE: hdl/power_sequencer_with_keepalive.sv
// Power sequencer top level: control state machine, keep-alive watchdog and shutdown timers.
//
// One item is taken per clock cycle, back to back. An accepted item lands in an input
// register; the state update and its result are computed from it in a single pass of
// short logic and written into the result register together with the new state,
// whenever the result register is empty or being taken downstream. The
// result register parts the two sides: the input stays open while a result waits, and
// only stalls when both the input register and the result register are full and the
// downstream side is not ready. Kinds of item (tuser): tick, keep-alive refresh,
// shutdown request; the fourth code is reported without changing anything. A tick
// samples button, ignition and CAN levels; in off any active source (or a pending
// restart) powers up, in on the watchdog, long-press and shutdown timers run, checked
// in the order forced reset, forced shutdown, requested shutdown. Register writes on
// the config channel are always accepted and take effect at the next reload of the
// corresponding counter; write them only while no item is in flight.
module power_sequencer_with_keepalive
	import pwrseq_pkg::*;
#(
	parameter int TICKS_PER_DELAY_UNIT = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] power_button, [1] ignition, [2] can_operative, [3] keepalive_enable,
	// [11:4] shutdown_delay, [15:12] zero
	input  logic [15:0] s_axis_tdata,
	// [1:0] action
	input  logic [1:0]  s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] control_state, [2] power_pin, [4:3] wake_cause, [5] can_seen,
	// [6] sd_prepare, [7] zero
	output logic [7:0]  m_axis_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] keepalive_ticks_q;
	logic [15:0] long_press_ticks_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic        btn_s1;
	logic        ign_s1;
	logic        can_s1;
	logic        kaen_s1;
	logic [7:0]  delay_s1;

	// sequencer state
	logic [1:0]      mode_q,       mode_d;
	logic            power_on_q,   power_on_d;
	logic [1:0]      cause_q,      cause_d;
	logic            can_latch_q,  can_latch_d;
	logic [15:0]     wd_count_q,   wd_count_d;
	logic            wd_en_q,      wd_en_d;
	logic [15:0]     press_cnt_q,  press_cnt_d;
	logic [SD_W-1:0] sd_count_q,   sd_count_d;
	logic            reset_flag_q, reset_flag_d;
	logic            press_flag_q, press_flag_d;
	logic            sd_flag_q,    sd_flag_d;
	logic            restart_q,    restart_d;
	logic            prepare_d;

	// result stage
	logic    out_valid_q;
	result_t result_q;

	logic            advance;
	logic            src_any;
	logic [1:0]      src_cause;
	logic [SD_W-1:0] sd_load;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, result_q.sd_prepare, result_q.can_seen,
		result_q.wake_cause, result_q.power_pin, result_q.control_state};

	// delayed shutdown load, kept modulo the counter width
	assign sd_load = SD_W'(SD_W'(delay_s1) * SD_W'(TICKS_PER_DELAY_UNIT));

	// wake sources by priority; CAN is the level sampled by this tick
	assign src_any   = btn_s1 || ign_s1 || can_s1;
	assign src_cause = btn_s1 ? CAUSE_BUTTON : (ign_s1 ? CAUSE_IGNITION : CAUSE_CAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_ticks_q  <= KEEPALIVE_RESET;
			long_press_ticks_q <= LONG_PRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEEPALIVE:  keepalive_ticks_q  <= cfg_data;
				REG_LONG_PRESS: long_press_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			btn_s1    <= s_axis_tdata[0];
			ign_s1    <= s_axis_tdata[1];
			can_s1    <= s_axis_tdata[2];
			kaen_s1   <= s_axis_tdata[3];
			delay_s1  <= s_axis_tdata[11:4];
		end
	end

	// next state for the item in the input register
	always_comb begin
		mode_d       = mode_q;
		power_on_d   = power_on_q;
		cause_d      = cause_q;
		can_latch_d  = can_latch_q;
		wd_count_d   = wd_count_q;
		wd_en_d      = wd_en_q;
		press_cnt_d  = press_cnt_q;
		sd_count_d   = sd_count_q;
		reset_flag_d = reset_flag_q;
		press_flag_d = press_flag_q;
		sd_flag_d    = sd_flag_q;
		restart_d    = restart_q;
		prepare_d    = 1'b0;

		unique case (action_s1)
			ACT_TICK: begin
				can_latch_d = can_s1;
				unique case (mode_q)
					MODE_INIT: begin
						cause_d    = CAUSE_NONE;
						power_on_d = 1'b0;
						mode_d     = MODE_OFF;
					end
					MODE_OFF: begin
						if (src_any) begin
							cause_d = src_cause;
						end
						if (src_any || restart_q) begin
							// power up with fresh timers
							reset_flag_d = 1'b0;
							press_flag_d = 1'b0;
							sd_flag_d    = 1'b0;
							restart_d    = 1'b0;
							wd_en_d      = 1'b0;
							press_cnt_d  = long_press_ticks_q;
							wd_count_d   = keepalive_ticks_q;
							sd_count_d   = '0;
							power_on_d   = 1'b1;
							mode_d       = MODE_ON;
						end
					end
					MODE_ON: begin
						if (wd_en_q && wd_count_q != '0) begin
							wd_count_d = wd_count_q - 16'd1;
							if (wd_count_q == 16'd1) begin
								reset_flag_d = 1'b1;
							end
						end
						if (btn_s1) begin
							if (press_cnt_q != '0) begin
								press_cnt_d = press_cnt_q - 16'd1;
								if (press_cnt_q == 16'd1) begin
									press_flag_d = 1'b1;
								end
							end
						end else begin
							press_cnt_d = long_press_ticks_q;
						end
						if (sd_count_q != '0) begin
							if (src_any) begin
								restart_d = 1'b1;
								cause_d   = src_cause;
							end
							sd_count_d = sd_count_q - SD_W'(1);
							if (sd_count_q == SD_W'(1)) begin
								sd_flag_d = 1'b1;
							end
						end
						priority if (reset_flag_d) begin
							mode_d = MODE_INIT;
						end else if (press_flag_d) begin
							mode_d = MODE_IDLE;
						end else if (sd_flag_d) begin
							mode_d = MODE_INIT;
						end
					end
					MODE_IDLE: begin
						// wait for button release
						if (!btn_s1) begin
							mode_d = MODE_INIT;
						end
					end
					default: ;
				endcase
			end
			ACT_KEEPALIVE: begin
				wd_count_d = keepalive_ticks_q;
				wd_en_d    = kaen_s1;
			end
			ACT_SHUTDOWN: begin
				if (delay_s1 == '0) begin
					sd_flag_d = 1'b1;
				end else begin
					prepare_d  = 1'b1;
					sd_count_d = sd_load;
				end
			end
			ACT_UNUSED: ;
			default: ;
		endcase
	end

	// state update, once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_INIT;
			power_on_q   <= 1'b0;
			cause_q      <= CAUSE_NONE;
			can_latch_q  <= 1'b0;
			wd_count_q   <= KEEPALIVE_RESET;
			wd_en_q      <= 1'b0;
			press_cnt_q  <= LONG_PRESS_RESET;
			sd_count_q   <= '0;
			reset_flag_q <= 1'b0;
			press_flag_q <= 1'b0;
			sd_flag_q    <= 1'b0;
			restart_q    <= 1'b0;
		end else if (advance) begin
			mode_q       <= mode_d;
			power_on_q   <= power_on_d;
			cause_q      <= cause_d;
			can_latch_q  <= can_latch_d;
			wd_count_q   <= wd_count_d;
			wd_en_q      <= wd_en_d;
			press_cnt_q  <= press_cnt_d;
			sd_count_q   <= sd_count_d;
			reset_flag_q <= reset_flag_d;
			press_flag_q <= press_flag_d;
			sd_flag_q    <= sd_flag_d;
			restart_q    <= restart_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.control_state <= mode_d;
			result_q.power_pin     <= power_on_d;
			result_q.wake_cause    <= cause_d;
			result_q.can_seen      <= can_latch_d;
			result_q.sd_prepare    <= prepare_d;
		end
	end

	// on always drives the power pin
	a_on_powered: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ON |-> power_on_q)
		else $error("power pin low in on state");

	// idle is only reached through a long press
	a_idle_press: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> press_flag_q)
		else $error("idle state without long-press flag");

	// a pending prepare result implies the countdown is loaded
	a_prepare_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.sd_prepare |-> sd_count_q != '0)
		else $error("prepare reported with empty shutdown countdown");

	// watchdog reload register follows a write
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_KEEPALIVE
		|=> keepalive_ticks_q == $past(cfg_data))
		else $error("keep-alive register not updated");

endmodule
